// ===== rtl/core/aema_pkg.sv =====
`default_nettype none

package aema_pkg;

  localparam int unsigned SampleBits  = 16;
  localparam int unsigned FracBits    = 10;
  localparam int unsigned AvgBits     = SampleBits + FracBits;
  localparam int unsigned AlphaBits   = 11;
  localparam int unsigned SensBits    = 16;
  localparam int unsigned MulABits    = SampleBits + 1;
  localparam int unsigned MulBBits    = AlphaBits + 1;
  localparam int unsigned ProdBits    = MulABits + MulBBits;
  localparam int unsigned SumBits     = ProdBits + 1;
  localparam int unsigned DvdBits     = SampleBits + AlphaBits;
  localparam int unsigned QuotBits    = AlphaBits;
  localparam int unsigned CntBits     = $clog2(QuotBits + 1);
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;

  localparam logic [AlphaBits-1:0] AlphaOne = AlphaBits'(1024);

  localparam logic [SensBits-1:0]  SensReset     = SensBits'(64);
  localparam logic [AlphaBits-1:0] AlphaMinReset = AlphaBits'(32);
  localparam logic [AlphaBits-1:0] AlphaMaxReset = AlphaBits'(1024);

  localparam logic [CfgIdxBits-1:0] CfgSensitivity = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgAlphaMin    = CfgIdxBits'(1);
  localparam logic [CfgIdxBits-1:0] CfgAlphaMax    = CfgIdxBits'(2);

  typedef struct packed {
    logic                start;
    logic [DvdBits-1:0]  dividend;
    logic [SensBits-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [QuotBits-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ERR   = 8'b0000_0010,
    S_MUL   = 8'b0000_0100,
    S_DIVLD = 8'b0000_1000,
    S_DIVW  = 8'b0001_0000,
    S_MUL2  = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  function automatic logic [AlphaBits-1:0] sat_alpha(input logic [AlphaBits-1:0] a);
    return (a > AlphaOne) ? AlphaOne : a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aema_div.sv =====
`default_nettype none

module aema_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire aema_pkg::div_req_t req_i,
  output aema_pkg::div_rsp_t      rsp_o
);
  import aema_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [SensBits-1:0] rem_q, rem_d;
  logic [QuotBits-1:0] low_q, low_d;
  logic [SensBits:0]   trial;
  logic                fits;

  // Restoring divide, one quotient bit per cycle; the dividend's upper part
  // is already below the divisor, so the quotient fits in QuotBits.
  assign trial = {rem_q, low_q[QuotBits-1]};
  assign fits  = trial >= {1'b0, req_i.divisor};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(QuotBits);
      rem_d  = req_i.dividend[DvdBits-1:QuotBits];
      low_d  = req_i.dividend[QuotBits-1:0];
    end else if (busy_q) begin
      rem_d = fits ? SensBits'(trial - {1'b0, req_i.divisor}) : trial[SensBits-1:0];
      low_d = {low_q[QuotBits-2:0], fits};
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = low_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("divider restarted while busy");
  a_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !req_i.start && cnt_q == CntBits'(1)) |=> done_q)
    else $error("divider missed done");

endmodule

`default_nettype wire

// ===== rtl/core/adaptive_ema_filter.sv =====
// Adaptive exponential moving average over unsigned sensor samples.
// Input channel: in_valid_i/in_ready_o with sample_i, one sample per item.
// Output channel: out_valid_o/out_ready_i with filtered_o (descaled
// average) and alpha_used_o (weight applied, scaled by 1024), one result
// per sample, in order.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 sensitivity, 1 weight floor, 2 weight ceiling, index 3 is ignored.
// Always ready; write only while no sample is in flight.
// From accept to result register, the first sample goes straight to the
// output step; when the error reaches the sensitivity, error, multiply,
// average multiply and sum steps run; otherwise the 11-step bit-serial
// divider that scales the weight runs too. in_ready_o is high only when
// the sequencer is idle, so no sample is taken while one is in flight.
// A finished result sits in the output register; the next sample is taken
// meanwhile, and its result waits in the last step until the receiver
// takes the previous one.
// Reset clears the average, arms first-sample load and restores the
// register defaults (64, 32, 1024).
`default_nettype none

module adaptive_ema_filter (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [aema_pkg::SampleBits-1:0]    sample_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [aema_pkg::SampleBits-1:0]         filtered_o,
  output logic [aema_pkg::AlphaBits-1:0]          alpha_used_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [aema_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  wire logic [aema_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import aema_pkg::*;

  state_e state_q, state_d;

  logic [SensBits-1:0]   sens_q, sens_d;
  logic [AlphaBits-1:0]  amin_cfg_q, amin_cfg_d;
  logic [AlphaBits-1:0]  amax_cfg_q, amax_cfg_d;
  logic                  first_q, first_d;
  logic                  out_valid_q, out_valid_d;

  logic [AvgBits-1:0]          avg_q, avg_d;
  logic [SampleBits-1:0]       sample_q, sample_d;
  logic signed [MulABits-1:0]  diff_q, diff_d;
  logic [SampleBits-1:0]       abs_q, abs_d;
  logic [AlphaBits-1:0]        amax_q, amax_d;
  logic [AlphaBits-1:0]        amin_q, amin_d;
  logic [AlphaBits-1:0]        alpha_q, alpha_d;
  logic signed [ProdBits-1:0]  mul_q, mul_d;
  logic [SampleBits-1:0]       filt_q, filt_d;
  logic [AlphaBits-1:0]        alpha_out_q, alpha_out_d;

  logic [AlphaBits-1:0]        amax_s, amin_s;
  logic [SampleBits-1:0]       current;
  logic signed [MulABits-1:0]  diff;
  logic signed [MulABits-1:0]  neg_diff;
  logic signed [MulABits-1:0]  mul_a;
  logic signed [MulBBits-1:0]  mul_b;
  logic signed [ProdBits-1:0]  product;
  logic signed [SumBits-1:0]   sum;
  logic [AvgBits-1:0]          sum_sat;
  logic                        in_fire, out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  aema_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign amax_s   = sat_alpha(amax_cfg_q);
  assign amin_s   = sat_alpha(amin_cfg_q);
  assign current  = avg_q[AvgBits-1:FracBits];
  assign diff     = $signed({1'b0, sample_q}) - $signed({1'b0, current});
  assign neg_diff = -diff;

  // One multiplier serves both the weight numerator and the average step.
  assign mul_a   = (state_q == S_MUL2) ? diff_q : $signed({1'b0, abs_q});
  assign mul_b   = (state_q == S_MUL2) ? $signed({1'b0, alpha_q})
                                       : $signed({1'b0, amax_q - amin_q});
  assign product = mul_a * mul_b;

  assign sum = $signed({{(SumBits-AvgBits){1'b0}}, avg_q}) + $signed({mul_q[ProdBits-1], mul_q});

  always_comb begin
    if (sum[SumBits-1]) begin
      sum_sat = '0;
    end else if (sum[SumBits-2:AvgBits] != '0) begin
      sum_sat = '1;
    end else begin
      sum_sat = sum[AvgBits-1:0];
    end
  end

  assign div_req.start    = (state_q == S_DIVLD);
  assign div_req.dividend = mul_q[DvdBits-1:0];
  assign div_req.divisor  = sens_q;

  always_comb begin
    state_d     = state_q;
    sens_d      = sens_q;
    amin_cfg_d  = amin_cfg_q;
    amax_cfg_d  = amax_cfg_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    avg_d       = avg_q;
    sample_d    = sample_q;
    diff_d      = diff_q;
    abs_d       = abs_q;
    amax_d      = amax_q;
    amin_d      = amin_q;
    alpha_d     = alpha_q;
    mul_d       = mul_q;
    filt_d      = filt_q;
    alpha_out_d = alpha_out_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgSensitivity: sens_d     = cfg_data_i[SensBits-1:0];
        CfgAlphaMin:    amin_cfg_d = cfg_data_i[AlphaBits-1:0];
        CfgAlphaMax:    amax_cfg_d = cfg_data_i[AlphaBits-1:0];
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          sample_d = sample_i;
          if (first_q) begin
            avg_d   = {sample_i, FracBits'(0)};
            alpha_d = AlphaOne;
            first_d = 1'b0;
            state_d = S_OUT;
          end else begin
            state_d = S_ERR;
          end
        end
      end
      S_ERR: begin
        diff_d  = diff;
        abs_d   = diff[MulABits-1] ? neg_diff[SampleBits-1:0] : diff[SampleBits-1:0];
        amax_d  = amax_s;
        amin_d  = (amin_s > amax_s) ? amax_s : amin_s;
        state_d = S_MUL;
      end
      S_MUL: begin
        if (abs_q >= sens_q) begin
          alpha_d = amax_q;
          state_d = S_MUL2;
        end else begin
          mul_d   = product;
          state_d = S_DIVLD;
        end
      end
      S_DIVLD: begin
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (div_rsp.done) begin
          alpha_d = amin_q + div_rsp.quotient;
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        mul_d   = product;
        state_d = S_SUM;
      end
      S_SUM: begin
        avg_d   = sum_sat;
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold the result until the output register frees up
        if (out_load) begin
          filt_d      = avg_q[AvgBits-1:FracBits];
          alpha_out_d = alpha_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sens_q      <= SensReset;
      amin_cfg_q  <= AlphaMinReset;
      amax_cfg_q  <= AlphaMaxReset;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
      avg_q       <= '0;
    end else begin
      state_q     <= state_d;
      sens_q      <= sens_d;
      amin_cfg_q  <= amin_cfg_d;
      amax_cfg_q  <= amax_cfg_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      avg_q       <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q    <= sample_d;
    diff_q      <= diff_d;
    abs_q       <= abs_d;
    amax_q      <= amax_d;
    amin_q      <= amin_d;
    alpha_q     <= alpha_d;
    mul_q       <= mul_d;
    filt_q      <= filt_d;
    alpha_out_q <= alpha_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filt_q;
  assign alpha_used_o = alpha_out_q;

  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (alpha_q <= AlphaOne)) else $error("weight above one");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE)) else $error("sequencer idle after accept");
  a_boost_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVW && div_rsp.done) |-> (div_rsp.quotient < AlphaOne))
    else $error("weight boost out of range");

endmodule

`default_nettype wire

// ===== bench/tb_adaptive_ema_filter.sv =====
module tb_adaptive_ema_filter;
  import aema_pkg::*;

  localparam logic [CfgIdxBits-1:0] CfgUnused = CfgIdxBits'(3);
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseItems = 190;

  typedef struct packed {
    logic [SampleBits-1:0] filtered;
    logic [AlphaBits-1:0]  alpha;
  } ema_out_t;

  class ema_scoreboard;
    logic [SensBits-1:0]  sens_q       = SensReset;
    logic [AlphaBits-1:0] weight_lo_q  = AlphaMinReset;
    logic [AlphaBits-1:0] weight_hi_q  = AlphaMaxReset;
    logic [AvgBits-1:0]   avg_q        = '0;
    logic                 first_q      = 1'b1;
    ema_out_t             outputs_due[$];
    int unsigned          errors       = 0;

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] data);
      case (idx)
        CfgSensitivity: sens_q = data[SensBits-1:0];
        CfgAlphaMin:    weight_lo_q = data[AlphaBits-1:0];
        CfgAlphaMax:    weight_hi_q = data[AlphaBits-1:0];
        default: ;
      endcase
    endfunction

    function ema_out_t advance_average(logic [SampleBits-1:0] raw);
      ema_out_t             o;
      logic [AlphaBits-1:0] hi;
      logic [AlphaBits-1:0] lo;
      logic [AlphaBits-1:0] alpha;
      longint               cur;
      longint               diff;
      longint               abs_err;
      longint               nxt;
      if (first_q) begin
        avg_q    = {raw, {FracBits{1'b0}}};
        first_q  = 1'b0;
        o.filtered = raw;
        o.alpha    = AlphaOne;
        return o;
      end
      hi = (weight_hi_q > AlphaOne) ? AlphaOne : weight_hi_q;
      lo = (weight_lo_q > AlphaOne) ? AlphaOne : weight_lo_q;
      if (lo > hi) lo = hi;
      cur     = longint'(avg_q >> FracBits);
      diff    = longint'(raw) - cur;
      abs_err = (diff < 0) ? -diff : diff;
      // interpolate the weight only below the sensitivity; no divide by zero
      if (abs_err >= longint'(sens_q)) begin
        alpha = hi;
      end else begin
        alpha = lo + AlphaBits'((abs_err * longint'(hi - lo)) / longint'(sens_q));
      end
      nxt = longint'(avg_q) + diff * longint'(alpha);
      if (nxt < 0) nxt = 0;
      if (nxt > (longint'(1) << AvgBits) - 1) nxt = (longint'(1) << AvgBits) - 1;
      avg_q      = nxt[AvgBits-1:0];
      o.filtered = avg_q[AvgBits-1:FracBits];
      o.alpha    = alpha;
      return o;
    endfunction

    function void note_sample(logic [SampleBits-1:0] raw);
      outputs_due.push_back(advance_average(raw));
    endfunction

    function void check_result(logic [SampleBits-1:0] filtered, logic [AlphaBits-1:0] alpha);
      ema_out_t exp_out;
      if (outputs_due.size() == 0) begin
        $error("result with no sample pending: filtered %0d alpha_used %0d", filtered, alpha);
        errors++;
        return;
      end
      exp_out = outputs_due.pop_front();
      if (filtered !== exp_out.filtered) begin
        $error("filtered expected %0d actual %0d", exp_out.filtered, filtered);
        errors++;
      end
      if (alpha !== exp_out.alpha) begin
        $error("alpha_used expected %0d actual %0d", exp_out.alpha, alpha);
        errors++;
      end
    endfunction

    function logic [SampleBits-1:0] level();
      return avg_q[AvgBits-1:FracBits];
    endfunction

    function int unsigned due();
      return outputs_due.size();
    endfunction
  endclass

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  logic [SampleBits-1:0]  sample_i    = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [SampleBits-1:0]  filtered_o;
  logic [AlphaBits-1:0]   alpha_used_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxBits-1:0]  cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_data_i  = '0;

  ema_scoreboard sb = new();
  bit            hold_off_req = 1'b0;

  adaptive_ema_filter uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .filtered_o   (filtered_o),
    .alpha_used_o (alpha_used_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_sample(sample_i);
      if (out_valid_o && out_ready_i) sb.check_result(filtered_o, alpha_used_o);
    end
  end

  task automatic push_sample(input logic [SampleBits-1:0] s);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input logic [CfgDataBits-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_settings(input logic [CfgDataBits-1:0] sens,
                               input logic [CfgDataBits-1:0] lo,
                               input logic [CfgDataBits-1:0] hi);
    if ($urandom_range(0, 2) == 0) write_reg(CfgUnused, CfgDataBits'($urandom));
    write_reg(CfgSensitivity, sens);
    write_reg(CfgAlphaMin, lo);
    write_reg(CfgAlphaMax, hi);
    cfg_valid_i <= 1'b0;
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // mostly stay within the sensitivity plus two of the average to reach the interpolation
  function automatic logic [SampleBits-1:0] pick_sample();
    int unsigned r;
    int unsigned span;
    longint      v;
    r    = $urandom_range(0, 99);
    span = int'(sb.sens_q) + 2;
    if (r < 55) begin
      v = longint'(sb.level()) + longint'($urandom_range(0, 2 * span)) - longint'(span);
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
    end else if (r < 80) begin
      v = longint'($urandom_range(0, 65535));
    end else if (r < 88) begin
      v = 0;
    end else if (r < 95) begin
      v = 65535;
    end else begin
      v = longint'(sb.level());
    end
    return v[SampleBits-1:0];
  endfunction

  function automatic logic [CfgDataBits-1:0] pick_alpha();
    int unsigned a;
    a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1024);
    return CfgDataBits'(a | ($urandom_range(0, 31) << AlphaBits));
  endfunction

  initial begin : rx
    int unsigned pick;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          out_ready_i <= 1'b1;
          repeat ($urandom_range(10, 80)) @(posedge clk_i);
        end else if (pick < 70) begin
          out_ready_i <= 1'b1;
        end else if (pick < 95) begin
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b0;
          repeat ($urandom_range(8, 50)) @(posedge clk_i);
        end
      end
    end
  end

  initial begin : tx
    logic [SampleBits-1:0] directed[] = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd32768,
                                          16'd32778, 16'd32841, 16'd32905, 16'd32842,
                                          16'd32841, 16'd32841, 16'd1, 16'd0};
    logic [CfgDataBits-1:0] s;
    logic [CfgDataBits-1:0] lo;
    logic [CfgDataBits-1:0] hi;
    int unsigned g;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first sample passes straight through, then full and partial weights
    foreach (directed[k]) push_sample(directed[k]);
    settle();

    // zero sensitivity always takes the largest weight
    load_settings(16'd0, 16'd100, 16'd900);
    push_sample(16'd0);
    push_sample(16'hFFFF);
    push_sample(16'd40000);
    settle();

    // a weight floor above the ceiling collapses the range
    load_settings(16'd500, 16'd900, 16'd100);
    push_sample(sb.level() + 16'd10);
    push_sample(sb.level() + 16'd300);
    push_sample(sb.level());
    settle();

    // weights above one saturate
    load_settings(16'd1000, 16'hFFFF, 16'hF5DC);
    push_sample(sb.level() + 16'd5);
    push_sample(sb.level() - 16'd700);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          s  = SensReset;
          lo = CfgDataBits'(AlphaMinReset);
          hi = CfgDataBits'(AlphaMaxReset);
        end
        1: begin s = 16'hFFFF; lo = 16'd0; hi = 16'd1024; end
        2: begin s = 16'd1; lo = 16'd1024; hi = 16'd0; end
        3: begin s = 16'd200; lo = 16'd0; hi = 16'd0; end
        default: begin
          s  = ($urandom_range(0, 3) == 0) ? CfgDataBits'($urandom) :
                                             CfgDataBits'($urandom_range(1, 400));
          lo = pick_alpha();
          hi = pick_alpha();
        end
      endcase
      load_settings(s, lo, hi);
      if (p == 3) hold_off_req = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        push_sample(pick_sample());
        // keep offering items back to back while the receiver holds off
        g = (p == 3 && i < 12) ? 0 : pick_gap();
        if (g != 0) begin
          in_valid_i <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      settle();
    end

    repeat (30) @(posedge clk_i);
    if (sb.errors == 0 && sb.due() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
